// ===== hw/rtl/smoothed_line_rasterizer_top_macros.svh =====
// Assertion macros used by the smoothed line rasterizer checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SMOOTHED_LINE_RASTERIZER_TOP_MACROS_SVH
`define SMOOTHED_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slr check failed");

// next-cycle implication, disabled during reset
`define SLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slr check failed");

`endif

// ===== hw/rtl/slr_pkg.sv =====
// Shared constants, types and helpers for the smoothed line rasterizer.
// No dependencies.
`timescale 1ns / 1ps

package slr_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int FULL_INTENSITY_DEF = 255;

    // output intensity field is fixed at one byte
    localparam int INT_W   = 8;
    localparam int INT_MAX = 255;
    // widest internal intensity (FULL_INTENSITY up to 65535)
    localparam int FI_MAX_W = 16;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        RES_IDLE  = 2'd0,
        RES_START = 2'd1,
        RES_STEP  = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic     load_in;
        logic     len;
        logic     prep;
        logic     step;
        logic     div_start;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic line_active;
        logic div_busy;
    } t_dp_stat;

    function automatic logic [INT_W-1:0] sat_int(input logic [FI_MAX_W-1:0] v);
        logic [INT_W-1:0] r;
        r = (v > FI_MAX_W'(INT_MAX)) ? INT_W'(INT_MAX) : v[INT_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/smoothed_line_rasterizer_top.sv =====
// Smoothed line rasterizer top level: stream ports around sequencer and datapath.
// Uses slr_pkg, slr_ctrl, slr_datapath (which holds slr_div).
`timescale 1ns / 1ps

// Bresenham line walker with per-pixel intensity from the walker's error term.
//
// Input stream (slave side): one beat per command. tuser = command
// (0 start a line, 1 step to the next pixel); tdata carries the endpoints,
// latched on every beat but used on a start beat only.
// Output stream (master side): exactly one beat per input beat. tdata holds
// pixel position and intensity, tuser = pixel_valid, tlast = last pixel.
// A step with no active line returns a beat with tuser low and zero data.
//
// Timing: a start beat passes span setup, error setup and output load; a
// step with no line active goes straight to output load. A step beat passes
// the walker step and divider load; the restoring divider then computes
// round(E / major), FI_W = clog2(FULL_INTENSITY+1) bits wide, one quotient
// bit per cycle, before output load. tready is high only while the sequencer is
// idle, so one command is in flight at a time; the next beat is taken as soon
// as the current result sits in the output register.
// When the receiver stalls, the output beat holds in its register; the
// sequencer accepts the next command, works it, and waits before loading
// until the held beat is taken. Reset (synchronous, active low) drops the
// output valid and leaves no line active.
module smoothed_line_rasterizer_top import slr_pkg::*; #(
    parameter int  COORD_BITS     = COORD_BITS_DEF,
    parameter int  FULL_INTENSITY = FULL_INTENSITY_DEF,
    localparam int S_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_BITS + INT_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata, low bit up: x_start, y_start, x_end, y_end, zero fill
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // tuser: command
    input  logic                i_s_axis_tuser,
    // master side
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata, low bit up: pixel_x, pixel_y, intensity, zero fill
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // tuser: pixel_valid
    output logic                o_m_axis_tuser,
    // tlast: last_pixel
    output logic                o_m_axis_tlast
);

    localparam int CB = COORD_BITS;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [CB-1:0]    w_pixel_x, w_pixel_y;
    logic [INT_W-1:0] w_intensity;

    // command sequencer; owns both handshakes
    slr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_axis_tvalid),
        .i_s_cmd   (i_s_axis_tuser),
        .o_s_tready(o_s_axis_tready),
        .i_m_tready(i_m_axis_tready),
        .o_m_tvalid(o_m_axis_tvalid),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // walker state, divider and the output beat register
    slr_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FULL_INTENSITY(FULL_INTENSITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_x_start    (i_s_axis_tdata[CB-1:0]),
        .i_y_start    (i_s_axis_tdata[2*CB-1:CB]),
        .i_x_end      (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_y_end      (i_s_axis_tdata[4*CB-1:3*CB]),
        .o_pixel_x    (w_pixel_x),
        .o_pixel_y    (w_pixel_y),
        .o_intensity  (w_intensity),
        .o_pixel_valid(o_m_axis_tuser),
        .o_last_pixel (o_m_axis_tlast)
    );

    // pack fields, zero fill to whole bytes
    assign o_m_axis_tdata = M_DATA_W'({w_intensity, w_pixel_y, w_pixel_x});

endmodule

// ===== hw/rtl/slr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits QUOT_W bits (dividend < divisor << QUOT_W).
`timescale 1ns / 1ps

module slr_div #(
    parameter int QUOT_W    = 8,
    parameter int DIVISOR_W = 13,
    parameter int DIVIDEND_W = DIVISOR_W + QUOT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [QUOT_W-1:0]     o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [QUOT_W-1:0]    r_quot;

    logic [DIVISOR_W:0] w_trial;
    logic [DIVISOR_W:0] w_diff;
    logic               w_fits;

    assign w_trial = {r_rem, r_quot[QUOT_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(QUOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[DIVIDEND_W-1:QUOT_W];
            r_quot <= i_dividend[QUOT_W-1:0];
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem  <= w_fits ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], w_fits};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/slr_datapath.sv =====
// Line walker datapath: endpoint latch, span setup, error update, intensity divide
// and the output beat register. Uses slr_pkg and slr_div.
`timescale 1ns / 1ps

module slr_datapath import slr_pkg::*; #(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int FULL_INTENSITY = FULL_INTENSITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [INT_W-1:0]      o_intensity,
    output logic                  o_pixel_valid,
    output logic                  o_last_pixel
);

    localparam int CB   = COORD_BITS;
    localparam int FI_W = $clog2(FULL_INTENSITY + 1);
    localparam int E_W  = CB + FI_W;
    localparam int N_W  = E_W + 1;
    localparam int D_W  = CB + 1;

    // latched endpoints
    logic [CB-1:0] r_xs, r_ys, r_xe, r_ye;
    // walker state
    logic [CB-1:0]  r_cur_x, r_cur_y;
    logic [1:0]     r_dir_x, r_dir_y;
    logic [CB-1:0]  r_major, r_minor;
    logic           r_swap;
    logic [E_W-1:0] r_err, r_wstep, r_wadd;
    logic [CB-1:0]  r_left;
    logic           r_active;
    // output beat
    logic [CB-1:0]    r_o_x, r_o_y;
    logic [INT_W-1:0] r_o_int;
    logic             r_o_valid, r_o_last;

    // span setup
    logic signed [CB:0] w_dx, w_dy, w_ndx, w_ndy;
    logic [CB-1:0]      w_ax, w_ay;
    logic               w_swap;

    assign w_dx  = $signed({r_xe[CB-1], r_xe}) - $signed({r_xs[CB-1], r_xs});
    assign w_dy  = $signed({r_ye[CB-1], r_ye}) - $signed({r_ys[CB-1], r_ys});
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;
    assign w_ax  = w_dx[CB] ? w_ndx[CB-1:0] : w_dx[CB-1:0];
    assign w_ay  = w_dy[CB] ? w_ndy[CB-1:0] : w_dy[CB-1:0];
    assign w_swap = w_ay > w_ax;

    // step
    logic          w_straight;
    logic [CB-1:0] w_sx, w_sy;

    assign w_straight = r_err <= r_wstep;
    assign w_sx = {{(CB-2){r_dir_x[1]}}, r_dir_x};
    assign w_sy = {{(CB-2){r_dir_y[1]}}, r_dir_y};

    // intensity divide: round(E / major) = (2E + major) / (2 major)
    logic [N_W-1:0]  w_dividend;
    logic [D_W-1:0]  w_divisor;
    logic [FI_W-1:0] w_quot;
    logic [FI_W-1:0] w_inten;
    logic            w_div_busy;

    assign w_dividend = (N_W'(r_err) << 1) + N_W'(r_major);
    assign w_divisor  = {r_major, 1'b0};

    slr_div #(
        .QUOT_W    (FI_W),
        .DIVISOR_W (D_W),
        .DIVIDEND_W(N_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(w_dividend),
        .i_divisor (w_divisor),
        .o_busy    (w_div_busy),
        .o_quot    (w_quot)
    );

    assign w_inten = (w_quot >= FI_W'(FULL_INTENSITY)) ? '0 : FI_W'(FULL_INTENSITY) - w_quot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_xs <= i_x_start;
            r_ys <= i_y_start;
            r_xe <= i_x_end;
            r_ye <= i_y_end;
        end
        if (i_cmd.len) begin
            r_cur_x <= r_xs;
            r_cur_y <= r_ys;
            r_dir_x <= w_dx[CB] ? 2'b11 : ((w_dx != '0) ? 2'b01 : 2'b00);
            r_dir_y <= w_dy[CB] ? 2'b11 : ((w_dy != '0) ? 2'b01 : 2'b00);
            r_swap  <= w_swap;
            r_major <= w_swap ? w_ay : w_ax;
            r_minor <= w_swap ? w_ax : w_ay;
        end
        if (i_cmd.prep) begin
            r_err   <= E_W'(FULL_INTENSITY / 2) * E_W'(r_major);
            r_wstep <= E_W'(FULL_INTENSITY) * E_W'(r_major - r_minor);
            r_wadd  <= E_W'(FULL_INTENSITY) * E_W'(r_minor);
        end
        if (i_cmd.step) begin
            if (w_straight) begin
                if (r_swap) begin
                    r_cur_y <= r_cur_y + w_sy;
                end else begin
                    r_cur_x <= r_cur_x + w_sx;
                end
                r_err <= r_err + r_wadd;
            end else begin
                r_cur_x <= r_cur_x + w_sx;
                r_cur_y <= r_cur_y + w_sy;
                r_err   <= r_err - r_wstep;
            end
        end
        if (i_cmd.prep) begin
            r_left <= r_major;
        end else if (i_cmd.step) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.prep) begin
            r_active <= r_major != '0;
        end else if (i_cmd.step && r_left == CB'(1)) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_START: begin
                    r_o_x     <= r_cur_x;
                    r_o_y     <= r_cur_y;
                    r_o_int   <= sat_int(FI_MAX_W'(FULL_INTENSITY));
                    r_o_valid <= 1'b1;
                    r_o_last  <= r_major == '0;
                end
                RES_STEP: begin
                    r_o_x     <= r_cur_x;
                    r_o_y     <= r_cur_y;
                    r_o_int   <= sat_int(FI_MAX_W'(w_inten));
                    r_o_valid <= 1'b1;
                    r_o_last  <= r_left == '0;
                end
                default: begin
                    r_o_x     <= '0;
                    r_o_y     <= '0;
                    r_o_int   <= '0;
                    r_o_valid <= 1'b0;
                    r_o_last  <= 1'b0;
                end
            endcase
        end
    end

    assign o_stat.line_active = r_active;
    assign o_stat.div_busy    = w_div_busy;

    assign o_pixel_x     = r_o_x;
    assign o_pixel_y     = r_o_y;
    assign o_intensity   = r_o_int;
    assign o_pixel_valid = r_o_valid;
    assign o_last_pixel  = r_o_last;

endmodule

// ===== hw/rtl/slr_ctrl.sv =====
// Sequencer for the line walker: input handshake, datapath commands, output valid.
// Uses slr_pkg.
`timescale 1ns / 1ps

module slr_ctrl import slr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_cmd,
    output logic     o_s_tready,
    input  logic     i_m_tready,
    output logic     o_m_tvalid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LEN   = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_STEP  = 7'b0001000,
        ST_DIVLD = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state   r_state, n_state;
    t_res_sel r_kind, n_kind;
    logic     r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd         = '0;
        o_cmd.res_sel = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_s_cmd == CMD_START) begin
                        n_kind  = RES_START;
                        n_state = ST_LEN;
                    end else if (i_stat.line_active) begin
                        n_kind  = RES_STEP;
                        n_state = ST_STEP;
                    end else begin
                        n_kind  = RES_IDLE;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_LEN: begin
                o_cmd.len = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_DIVLD;
            end
            ST_DIVLD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // load only when the output register is free or draining
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= RES_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = r_state == ST_IDLE;
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== hw/rtl/slr_checker.sv =====
// Port-level checks for the smoothed line rasterizer, bound to its top level.
// Uses slr_pkg and smoothed_line_rasterizer_top_macros.svh.
`timescale 1ns / 1ps
`include "smoothed_line_rasterizer_top_macros.svh"

module slr_checker import slr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int M_DATA_W   = ((2 * COORD_BITS + INT_W + 7) / 8) * 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic                o_m_axis_tuser,
    input logic                o_m_axis_tlast
);

    // one command in flight: an accepted beat closes the input side
    `SLR_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready)

    // stalled output beat holds
    `SLR_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast))

    // last pixel is always a real pixel
    `SLR_ASSERT_NOW(a_last_is_pixel, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser)

    // no-pixel beat carries zero data
    `SLR_ASSERT_NOW(a_idle_zero, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0)

endmodule

bind smoothed_line_rasterizer_top slr_checker #(
    .COORD_BITS(COORD_BITS)
) u_slr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);

// ===== verif/smoothed_line_rasterizer_top_tb.sv =====
// Self-checking testbench for the smoothed line rasterizer top level.
// Depends on slr_pkg and the smoothed_line_rasterizer_top RTL.
`timescale 1ns / 1ps

module smoothed_line_rasterizer_top_tb;
    import slr_pkg::*;

    localparam int CW       = COORD_BITS_DEF;
    localparam int FULL     = FULL_INTENSITY_DEF;
    localparam int S_DATA_W = ((4 * CW + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * CW + INT_W + 7) / 8) * 8;
    localparam int CMIN     = -(1 << (CW - 1));
    localparam int CMAX     = (1 << (CW - 1)) - 1;
    // least number of random items queued per random phase
    localparam int PHASE_ITEMS = 481;
    // cycles to watch for stray beats once nothing is expected
    localparam int DRAIN_CYCLES = 40;

    // one slave-side beat
    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] ye;
        logic [CW-1:0] xe;
        logic [CW-1:0] ys;
        logic [CW-1:0] xs;
    } t_line_cmd;

    // one master-side beat
    typedef struct {
        logic [CW-1:0]    px;
        logic [CW-1:0]    py;
        logic [INT_W-1:0] inten;
        logic             is_valid;
        logic             is_last;
    } t_pixel;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // tdata, low bit up: x_start, y_start, x_end, y_end
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    // tuser: command
    logic                i_s_axis_tuser = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // tdata, low bit up: pixel_x, pixel_y, intensity
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    // tuser: pixel_valid
    logic                o_m_axis_tuser;
    // tlast: last_pixel
    logic                o_m_axis_tlast;

    smoothed_line_rasterizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_line_cmd line_cmd_q[$];
    t_pixel    pixel_expected_q[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  beat_taken     = 1'b0;
    int  queued_items   = 0;
    int  fail_count     = 0;
    int  n_starts       = 0;
    int  n_steps        = 0;
    int  n_pixels       = 0;
    int  n_lines_done   = 0;

    // walker state mirrored from the block
    logic [CW-1:0] wk_x;
    logic [CW-1:0] wk_y;
    int            wk_dir_x;
    int            wk_dir_y;
    int            wk_major;
    int            wk_minor;
    bit            wk_swapped;
    int            wk_err;
    int            wk_left;
    bit            wk_active;

    initial begin
        wk_x = '0; wk_y = '0; wk_dir_x = 0; wk_dir_y = 0;
        wk_major = 0; wk_minor = 0; wk_swapped = 1'b0;
        wk_err = 0; wk_left = 0; wk_active = 1'b0;
    end

    // Advance the mirrored walker by one command and return the pixel it gives.
    task automatic walk_line(input t_line_cmd c, output t_pixel p);
        int xs, ys, dx, dy, ax, ay, straight, q, inten;
        p.px = '0; p.py = '0; p.inten = '0; p.is_valid = 1'b0; p.is_last = 1'b0;
        if (c.cmd == CMD_START) begin
            xs = $signed(c.xs);
            ys = $signed(c.ys);
            dx = $signed(c.xe) - xs;
            dy = $signed(c.ye) - ys;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            wk_dir_x   = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            wk_dir_y   = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            // equal spans keep x as the major axis
            wk_swapped = (ay > ax);
            wk_major   = wk_swapped ? ay : ax;
            wk_minor   = wk_swapped ? ax : ay;
            wk_err     = (FULL / 2) * wk_major;
            wk_x       = c.xs;
            wk_y       = c.ys;
            wk_left    = wk_major;
            wk_active  = (wk_major != 0);
            p.px = wk_x; p.py = wk_y;
            p.inten    = (FULL > INT_MAX) ? INT_W'(INT_MAX) : INT_W'(FULL);
            p.is_valid = 1'b1;
            p.is_last  = (wk_major == 0);
        end else if (wk_active && wk_major != 0) begin
            straight = FULL * (wk_major - wk_minor);
            if (wk_err <= straight) begin
                if (wk_swapped) wk_y = wk_y + CW'(wk_dir_y);
                else            wk_x = wk_x + CW'(wk_dir_x);
                wk_err = wk_err + FULL * wk_minor;
            end else begin
                wk_x = wk_x + CW'(wk_dir_x);
                wk_y = wk_y + CW'(wk_dir_y);
                wk_err = wk_err - straight;
            end
            // round half up of E / major
            q = (2 * wk_err + wk_major) / (2 * wk_major);
            inten = (q >= FULL) ? 0 : FULL - q;
            wk_left--;
            if (wk_left == 0) wk_active = 1'b0;
            p.px = wk_x; p.py = wk_y;
            p.inten    = (inten > INT_MAX) ? INT_W'(INT_MAX) : INT_W'(inten);
            p.is_valid = 1'b1;
            p.is_last  = (wk_left == 0);
        end
        // a step with no line active leaves everything at zero
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus queue helpers
    // ---------------------------------------------------------------
    task automatic queue_item(input logic cmd, input int xs, input int ys,
                              input int xe, input int ye);
        t_line_cmd c;
        c.cmd = cmd;
        c.xs = CW'(xs); c.ys = CW'(ys); c.xe = CW'(xe); c.ye = CW'(ye);
        line_cmd_q.push_back(c);
        queued_items++;
    endtask

    // step beats carry random endpoints, which the block must ignore
    task automatic queue_steps(input int n);
        repeat (n) queue_item(CMD_STEP, $urandom_range(CMAX - CMIN) + CMIN,
                              $urandom_range(CMAX - CMIN) + CMIN,
                              $urandom_range(CMAX - CMIN) + CMIN,
                              $urandom_range(CMAX - CMIN) + CMIN);
    endtask

    task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                              input int steps);
        queue_item(CMD_START, xs, ys, xe, ye);
        queue_steps(steps);
    endtask

    // Pick an end point near the start; reflect if it would leave the range.
    function automatic int near_end(input int s, input int span);
        int d, e;
        d = int'($urandom_range(2 * span)) - span;
        e = s + d;
        if (e > CMAX || e < CMIN) e = s - d;
        return e;
    endfunction

    // One random sequence: mostly a well-formed walk, sometimes abandoned or noise.
    task automatic queue_random_seq();
        int xs, ys, xe, ye, span, major, ax, ay, steps, r, w;
        r = $urandom_range(99);
        if (r < 5) begin
            queue_steps($urandom_range(1, 3));
            return;
        end
        xs = int'($urandom_range(CMAX - CMIN)) + CMIN;
        ys = int'($urandom_range(CMAX - CMIN)) + CMIN;
        if (r < 97) begin
            span = (r < 75) ? 12 : ((r < 93) ? 40 : 150);
            xe = near_end(xs, span);
            ye = near_end(ys, span);
        end else begin
            xe = int'($urandom_range(CMAX - CMIN)) + CMIN;
            ye = int'($urandom_range(CMAX - CMIN)) + CMIN;
        end
        ax = (xe > xs) ? xe - xs : xs - xe;
        ay = (ye > ys) ? ye - ys : ys - ye;
        major = (ax > ay) ? ax : ay;
        w = $urandom_range(99);
        if (w < 80) steps = major + $urandom_range(0, 2);
        else        steps = $urandom_range(0, major);
        // long lines are cut short by the next start
        if (r >= 97 && steps > 12) steps = $urandom_range(0, 12);
        queue_line(xs, ys, xe, ye, steps);
    endtask

    // ---------------------------------------------------------------
    // Driver: slave-side beats change at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_line_cmd c;
        bit        free;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
            beat_taken = 1'b0;
        end else begin
            free = beat_taken || !i_s_axis_tvalid;
            beat_taken = 1'b0;
            if (free) begin
                if (line_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = line_cmd_q.pop_front();
                    i_s_axis_tdata  <= S_DATA_W'({c.ye, c.xe, c.ys, c.xs});
                    i_s_axis_tuser  <= c.cmd;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_cmd c;
        t_pixel    want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            c.cmd = i_s_axis_tuser;
            {c.ye, c.xe, c.ys, c.xs} = i_s_axis_tdata[4*CW-1:0];
            walk_line(c, want);
            pixel_expected_q.push_back(want);
            if (c.cmd == CMD_START) n_starts++;
            else                    n_steps++;
            beat_taken = 1'b1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pixel_expected_q.size() == 0) begin
                $display("%0t ns: unexpected output beat, expected none, actual %0h/%0b/%0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = pixel_expected_q.pop_front();
                check_field("pixel_x", want.px, o_m_axis_tdata[CW-1:0]);
                check_field("pixel_y", want.py, o_m_axis_tdata[2*CW-1:CW]);
                check_field("intensity", want.inten, o_m_axis_tdata[2*CW+INT_W-1:2*CW]);
                check_field("tdata fill", 0, o_m_axis_tdata >> (2 * CW + INT_W));
                check_field("pixel_valid", want.is_valid, o_m_axis_tuser);
                check_field("last_pixel", want.is_last, o_m_axis_tlast);
                if (want.is_valid) n_pixels++;
                if (want.is_last)  n_lines_done++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencing of phases
    // ---------------------------------------------------------------
    task automatic wait_drained();
        while (line_cmd_q.size() != 0 || i_s_axis_tvalid || pixel_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = queued_items + PHASE_ITEMS;
        while (queued_items < target) queue_random_seq();
        // sender holds off here until every result is back
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        queue_steps(1);                                 // step with no line
        queue_line(0, 0, 0, 0, 1);                      // zero-length line, then idle step
        queue_line(CMIN, CMIN, CMAX, CMAX, 2);          // longest diagonal, equal spans
        queue_line(CMAX, CMIN, CMIN, CMAX, 2);          // start while active
        queue_line(CMAX, CMAX, CMAX, CMAX, 0);          // zero length at the corner
        queue_line(-1, 2, 1, -3, 6);                    // steep: swapped axes, one step past end
        queue_line(0, 0, -3, 3, 3);                     // equal spans, small
        queue_line(10, -4, 7, -4, 3);                   // horizontal, negative direction
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(8, 8);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d start and %0d step beats, %0d pixels, %0d completed lines,",
                 n_starts, n_steps, n_pixels, n_lines_done);
        $display("under free-running, sender-idle, receiver-stall and mixed pressure.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1_500_000;
        $display("Timeout with %0d results outstanding", pixel_expected_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
